### rtl/mpq_pkg.sv
package mpq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_KEY_WIDTH   = 16;
    localparam int KEY_MAX_W       = 32;
    localparam int ID_W            = 4;
    localparam int SORT_KEY_W      = 16;
    localparam int LEN_W           = 5;
    localparam int MODE_W          = 3;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    localparam logic [MODE_W-1:0] MODE_FCFS = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RR   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PRIO = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SJF  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SRTN = 3'd4;
    localparam logic [MODE_W-1:0] MODE_EDF  = 3'd5;

    typedef struct packed {
        logic                  func;
        logic [ID_W-1:0]       thread_id;
        logic                  is_ready;
        logic [SORT_KEY_W-1:0] sort_key;
    } in_word_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [ID_W-1:0]  popped_thread;
        logic [LEN_W-1:0] queue_length;
    } out_word_t;

    // true when a queued entry with key ek stays ahead of a new entry with key nk
    function automatic logic stays_ahead(input logic [MODE_W-1:0] mode,
                                         input logic [KEY_MAX_W-1:0] ek,
                                         input logic [KEY_MAX_W-1:0] nk);
        logic r;
        r = 1'b1;
        case (mode) inside
            MODE_PRIO:                     r = (ek >= nk);
            MODE_SJF, MODE_SRTN, MODE_EDF: r = (ek <= nk);
            default:                       r = 1'b1;
        endcase
        return r;
    endfunction

endpackage

### rtl/mpq_ram.sv
module mpq_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/mpq_apb.sv
module mpq_apb (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output logic [mpq_pkg::MODE_W-1:0] mode
);

    import mpq_pkg::*;

    localparam logic REG_MODE = 1'b0;

    logic [MODE_W-1:0] mode_reg;
    logic [MODE_W-1:0] mode_next;
    logic              wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_MODE);

    always_comb
    begin
        mode_next = mode_reg;
        if (wr_hit)
        begin
            mode_next = pwdata[MODE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_FCFS;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            REG_MODE: prdata = {{(32-MODE_W){1'b0}}, mode_reg};
            default:  prdata = '0;
        endcase
    end

    assign mode = mode_reg;

endmodule

### rtl/mpq_seq.sv
module mpq_seq #(
    parameter int QUEUE_DEPTH = mpq_pkg::DEF_QUEUE_DEPTH,
    parameter int KEY_WIDTH   = mpq_pkg::DEF_KEY_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [mpq_pkg::MODE_W-1:0]     mode,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  mpq_pkg::in_word_t              in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output mpq_pkg::out_word_t             out_data,
    output logic                           wr_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
    output logic [mpq_pkg::ID_W+KEY_WIDTH-1:0] wr_data,
    output logic                           rd_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
    input  logic [mpq_pkg::ID_W+KEY_WIDTH-1:0] rd_data
);

    import mpq_pkg::*;

    localparam int AW    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_POP,
        S_DONE
    } state_t;

    state_t                state_reg, state_next;
    in_word_t              op_reg, op_next;
    logic [KEY_WIDTH-1:0]  key_reg, key_next;
    logic [CNT_W-1:0]      size_reg, size_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      pos_reg, pos_next;
    logic                  found_reg, found_next;
    logic                  dup_reg, dup_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic [AW-1:0]         rd_addr_reg, rd_addr_next;
    logic [1:0]            status_reg, status_next;
    logic [ID_W-1:0]       popped_reg, popped_next;
    logic                  out_valid_reg, out_valid_next;
    out_word_t             out_data_reg, out_data_next;

    logic [ID_W-1:0]       rd_id;
    logic [KEY_WIDTH-1:0]  rd_key;

    assign rd_id  = rd_data[ID_W+KEY_WIDTH-1:KEY_WIDTH];
    assign rd_key = rd_data[KEY_WIDTH-1:0];

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        size_next      = size_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        found_next     = found_reg;
        dup_next       = dup_reg;
        rd_vld_next    = 1'b0;
        rd_addr_next   = rd_addr_reg;
        status_next    = status_reg;
        popped_next    = popped_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[AW-1:0];
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = in_data;
                    key_next    = KEY_WIDTH'(in_data.sort_key);
                    idx_next    = '0;
                    found_next  = 1'b0;
                    dup_next    = 1'b0;
                    popped_next = '0;
                    status_next = ST_OK;
                    if (in_data.func == FUNC_POP)
                    begin
                        if (size_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_POP;
                        end
                    end
                    else if (!in_data.is_ready)
                    begin
                        status_next = ST_IGNORED;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            // read every entry: duplicate check and first entry the new one precedes
            S_SCAN:
            begin
                if (idx_reg < size_reg)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = idx_reg[AW-1:0];
                    rd_vld_next  = 1'b1;
                    rd_addr_next = idx_reg[AW-1:0];
                    idx_next     = idx_reg + CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    if (rd_id == op_reg.thread_id)
                    begin
                        dup_next = 1'b1;
                    end
                    if (!found_reg && !stays_ahead(mode, KEY_MAX_W'(rd_key),
                                                   KEY_MAX_W'(key_reg)))
                    begin
                        found_next = 1'b1;
                        pos_next   = CNT_W'(rd_addr_reg);
                    end
                end
                if (idx_reg == size_reg && !rd_vld_reg)
                begin
                    if (dup_reg)
                    begin
                        status_next = ST_IGNORED;
                        state_next  = S_DONE;
                    end
                    else if (size_reg == CNT_W'(QUEUE_DEPTH))
                    begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        if (!found_reg)
                        begin
                            pos_next = size_reg;
                        end
                        idx_next   = size_reg;
                        state_next = S_SHIFT;
                    end
                end
            end
            // move entries pos..size-1 up by one, tail first, then drop in the new one
            S_SHIFT:
            begin
                if (idx_reg > pos_reg)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = AW'(idx_reg - CNT_W'(1));
                    rd_vld_next  = 1'b1;
                    rd_addr_next = AW'(idx_reg - CNT_W'(1));
                    idx_next     = idx_reg - CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = rd_addr_reg + AW'(1);
                    wr_data = rd_data;
                end
                else if (idx_reg == pos_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg[AW-1:0];
                    wr_data    = {op_reg.thread_id, key_reg};
                    size_next  = size_reg + CNT_W'(1);
                    state_next = S_DONE;
                end
            end
            // take the head, move the rest down by one
            S_POP:
            begin
                if (idx_reg < size_reg)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = idx_reg[AW-1:0];
                    rd_vld_next  = 1'b1;
                    rd_addr_next = idx_reg[AW-1:0];
                    idx_next     = idx_reg + CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    if (rd_addr_reg == '0)
                    begin
                        popped_next = rd_id;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = rd_addr_reg - AW'(1);
                        wr_data = rd_data;
                    end
                end
                if (idx_reg == size_reg && !rd_vld_reg)
                begin
                    size_next  = size_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.status        = status_reg;
                    out_data_next.popped_thread = popped_reg;
                    out_data_next.queue_length  = LEN_W'(size_reg);
                    state_next                  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            size_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            dup_reg       <= 1'b0;
            idx_reg       <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            dup_reg       <= dup_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        rd_addr_reg  <= rd_addr_next;
        status_reg   <= status_next;
        popped_reg   <= popped_next;
        out_data_reg <= out_data_next;
    end

    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        size_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue size above depth");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> !wr_en)
        else $error("memory write outside a walk");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second word taken while one is in work");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!out_valid_reg || out_ready)) |=> out_valid_reg)
        else $error("finished word not presented");

endmodule

### rtl/multi_policy_ready_queue_unit.sv
// Work per word, n = queue length: a pop reads all n entries and moves each behind the head
// down by one; a push reads all n, then moves the entries from its slot to the tail up by one;
// a duplicate or full push reads all n; a not-ready push or empty-queue pop reads none. A
// result also waits for out_ready on the prior one. One word at a time, the next taken in
// the cycle after the result is loaded; walks use the single read port, one entry a cycle.
// Reset (rst_n, async, active low): queue empty, mode FCFS, no word pending;
// the entry memory is not cleared and entries at or beyond the length are never read.
module multi_policy_ready_queue_unit #(
    parameter int QUEUE_DEPTH = mpq_pkg::DEF_QUEUE_DEPTH,
    parameter int KEY_WIDTH   = mpq_pkg::DEF_KEY_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  mpq_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output mpq_pkg::out_word_t out_data
);

    import mpq_pkg::*;

    localparam int AW  = $clog2(QUEUE_DEPTH);
    localparam int EW  = ID_W + KEY_WIDTH;

    logic [MODE_W-1:0] mode;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [EW-1:0]     wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [EW-1:0]     rd_data;

    mpq_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .mode    (mode)
    );

    mpq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mpq_seq #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

endmodule

### bench/mpq_result_checker.sv
`timescale 1ns / 100ps

module mpq_result_checker #(
    parameter logic [2:0] MODE_ADDR = 3'd0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               in_valid,
    input  logic               in_ready,
    input  mpq_pkg::in_word_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  mpq_pkg::out_word_t out_data,
    output int                 mismatch_count,
    output int                 pending_results,
    output int                 results_checked
);

    import mpq_pkg::*;

    localparam int DEPTH = DEF_QUEUE_DEPTH;
    localparam int MAX_PRINTED = 50;

    logic [ID_W-1:0]       ready_ids  [DEPTH];
    logic [SORT_KEY_W-1:0] ready_keys [DEPTH];
    int                    depth_used;
    logic [MODE_W-1:0]     policy;
    out_word_t             expected_results [$];

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED)
        begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // applies one word to the shadow queue and returns the result it should produce
    function automatic out_word_t schedule_word(input in_word_t w);
        out_word_t r;
        int        slot;
        int        i;
        bit        ahead;
        bit        dup;
        r        = '0;
        r.status = ST_OK;
        if (w.func == FUNC_POP)
        begin
            if (depth_used == 0)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                r.popped_thread = ready_ids[0];
                for (i = 0; i < depth_used - 1; i++)
                begin
                    ready_ids[i]  = ready_ids[i+1];
                    ready_keys[i] = ready_keys[i+1];
                end
                depth_used--;
            end
        end
        else
        begin
            dup = 1'b0;
            for (i = 0; i < depth_used; i++)
            begin
                if (ready_ids[i] == w.thread_id)
                begin
                    dup = 1'b1;
                end
            end
            if (!w.is_ready || dup)
            begin
                r.status = ST_IGNORED;
            end
            else if (depth_used >= DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                // walk from the head; stop at the first entry the new one must precede
                slot  = 0;
                ahead = 1'b1;
                while (slot < depth_used && ahead)
                begin
                    case (policy) inside
                        MODE_PRIO:                     ahead = ready_keys[slot] >= w.sort_key;
                        MODE_SJF, MODE_SRTN, MODE_EDF: ahead = ready_keys[slot] <= w.sort_key;
                        default:                       ahead = 1'b1;
                    endcase
                    if (ahead)
                    begin
                        slot++;
                    end
                end
                for (i = depth_used; i > slot; i--)
                begin
                    ready_ids[i]  = ready_ids[i-1];
                    ready_keys[i] = ready_keys[i-1];
                end
                ready_ids[slot]  = w.thread_id;
                ready_keys[slot] = w.sort_key;
                depth_used++;
            end
        end
        r.queue_length = depth_used[LEN_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        out_word_t got;
        if (!rst_n)
        begin
            depth_used      = 0;
            policy          = MODE_FCFS;
            mismatch_count  = 0;
            results_checked = 0;
            expected_results.delete();
            pending_results <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == MODE_ADDR)
            begin
                policy = pwdata[MODE_W-1:0];
            end
            // output side first so a stray word is never matched against one just accepted
            if (out_valid && out_ready)
            begin
                got = out_data;
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("result word with nothing expected: %p", got));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                    begin
                        report_mismatch($sformatf("result %0d: status expected %0d, got %0d",
                                                  results_checked, want.status, got.status));
                    end
                    if (got.popped_thread !== want.popped_thread)
                    begin
                        report_mismatch($sformatf("result %0d: popped_thread expected %0d, got %0d",
                                                  results_checked, want.popped_thread,
                                                  got.popped_thread));
                    end
                    if (got.queue_length !== want.queue_length)
                    begin
                        report_mismatch($sformatf("result %0d: queue_length expected %0d, got %0d",
                                                  results_checked, want.queue_length,
                                                  got.queue_length));
                    end
                end
                results_checked++;
            end
            if (in_valid && in_ready)
            begin
                expected_results.push_back(schedule_word(in_data));
            end
            pending_results <= expected_results.size();
        end
    end

endmodule

### bench/tb_multi_policy_ready_queue_unit.sv
`timescale 1ns / 100ps

module tb_multi_policy_ready_queue_unit;

    import mpq_pkg::*;

    localparam logic [2:0]        ADDR_SCHED_MODE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SPARE6     = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE7     = 3'd7;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int DRAIN_CYCLES   = 2 * DEF_QUEUE_DEPTH + 8;
    localparam int SEGMENT_WORDS  = 28;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    in_word_t    in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_word_t   out_data;

    int mismatches;
    int pending;
    int checked;
    int in_idle_pct  = 10;
    int out_idle_pct = 54;
    int words_sent   = 0;
    int cycles       = 0;

    logic [MODE_W-1:0] mode_plan [8] = '{MODE_FCFS, MODE_EDF, MODE_PRIO, MODE_SPARE7,
                                         MODE_SJF, MODE_RR, MODE_SRTN, MODE_SPARE6};

    always #5 clk = ~clk;

    multi_policy_ready_queue_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    mpq_result_checker #(
        .MODE_ADDR (ADDR_SCHED_MODE)
    ) queue_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .mismatch_count  (mismatches),
        .pending_results (pending),
        .results_checked (checked)
    );

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= TIMEOUT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d results still pending", cycles, pending);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // called at a rising edge; returns at the edge where the word is taken
    task automatic send_word(input in_word_t w);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        words_sent++;
    endtask

    task automatic push_thread(input logic [ID_W-1:0] id, input logic rdy,
                               input logic [SORT_KEY_W-1:0] key);
        in_word_t w;
        w.func      = FUNC_PUSH;
        w.thread_id = id;
        w.is_ready  = rdy;
        w.sort_key  = key;
        send_word(w);
    endtask

    // id, ready and key carry junk on a pop
    task automatic pop_thread();
        in_word_t    w;
        logic [31:0] junk;
        junk        = $urandom;
        w           = junk[$bits(in_word_t)-1:0];
        w.func      = FUNC_POP;
        send_word(w);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_mode(input logic [MODE_W-1:0] m);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SCHED_MODE;
        pwdata  <= 32'(m);
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // small keys give plenty of ties
    function automatic logic [SORT_KEY_W-1:0] pick_key();
        logic [SORT_KEY_W-1:0] k;
        case ($urandom_range(9))
            0, 1, 2, 3: k = SORT_KEY_W'($urandom_range(3));
            4:          k = '0;
            5:          k = '1;
            default:    k = SORT_KEY_W'($urandom);
        endcase
        return k;
    endfunction

    task automatic run_segment(input int words);
        int              start;
        int              k;
        int              j;
        logic [ID_W-1:0] order [DEF_QUEUE_DEPTH];
        logic [ID_W-1:0] tmp;
        start = words_sent;
        while (words_sent - start < words)
        begin
            case ($urandom_range(9))
                0, 1:
                begin
                    // empty the queue, fill it with all distinct ids, then push two repeats of queued ids
                    repeat (DEF_QUEUE_DEPTH + 1)
                    begin
                        pop_thread();
                    end
                    for (k = 0; k < DEF_QUEUE_DEPTH; k++)
                    begin
                        order[k] = ID_W'(k);
                    end
                    for (k = DEF_QUEUE_DEPTH - 1; k > 0; k--)
                    begin
                        j        = $urandom_range(k);
                        tmp      = order[k];
                        order[k] = order[j];
                        order[j] = tmp;
                    end
                    for (k = 0; k < DEF_QUEUE_DEPTH; k++)
                    begin
                        push_thread(order[k], 1'b1, pick_key());
                    end
                    repeat (2)
                    begin
                        push_thread(ID_W'($urandom), 1'b1, pick_key());
                    end
                end
                2:
                begin
                    repeat ($urandom_range(4, 12))
                    begin
                        pop_thread();
                    end
                end
                default:
                begin
                    repeat ($urandom_range(4, 12))
                    begin
                        if ($urandom_range(99) < 40)
                        begin
                            pop_thread();
                        end
                        else
                        begin
                            push_thread(ID_W'($urandom), $urandom_range(99) < 88, pick_key());
                        end
                    end
                end
            endcase
        end
    endtask

    initial
    begin
        int phase;
        int seg;
        repeat (12)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pop, not ready, extremes, duplicate, ties, mode change, spare mode
        pop_thread();
        push_thread(4'd15, 1'b0, 16'hffff);
        push_thread(4'd0, 1'b1, 16'h0000);
        push_thread(4'd15, 1'b1, 16'hffff);
        push_thread(4'd0, 1'b1, 16'h1234);
        repeat (3)
        begin
            pop_thread();
        end
        set_mode(MODE_PRIO);
        push_thread(4'd1, 1'b1, 16'd5);
        push_thread(4'd2, 1'b1, 16'd9);
        push_thread(4'd3, 1'b1, 16'd5);
        push_thread(4'd4, 1'b1, 16'd9);
        // queued order stays descending while new words sort ascending
        set_mode(MODE_SJF);
        push_thread(4'd5, 1'b1, 16'd7);
        repeat (5)
        begin
            pop_thread();
        end
        set_mode(MODE_SPARE7);
        push_thread(4'd6, 1'b1, 16'hffff);
        push_thread(4'd7, 1'b1, 16'h0000);
        repeat (2)
        begin
            pop_thread();
        end

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       begin in_idle_pct = 10; out_idle_pct = 54; end
                1:       begin in_idle_pct = 54; out_idle_pct = 10; end
                default: begin in_idle_pct = 0;  out_idle_pct = 0;  end
            endcase
            for (seg = 0; seg < 8; seg++)
            begin
                set_mode(mode_plan[(seg + 3 * phase) % 8]);
                run_segment(SEGMENT_WORDS);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES)
        begin
            @(posedge clk);
        end

        $display("Covered %0d words: push/pop under all eight mode codes, ties, duplicates,",
                 words_sent);
        $display("not-ready pushes, full and empty queue; %0d results checked.", checked);
        if (mismatches == 0 && pending == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("%0d mismatches, %0d results never arrived", mismatches, pending);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### multi_policy_ready_queue_unit.f
rtl/mpq_pkg.sv
rtl/mpq_ram.sv
rtl/mpq_apb.sv
rtl/mpq_seq.sv
rtl/multi_policy_ready_queue_unit.sv
bench/mpq_result_checker.sv
bench/tb_multi_policy_ready_queue_unit.sv
